/* design/udcr_pkg.sv */
// Package for the UDP debug character receiver.
// Holds the codes, header offsets, sizes and the queue beat type shared by all modules.
`default_nettype none
package udcr_pkg;

	localparam int FIFO_DEPTH  = 256;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;

	localparam logic [1:0] REG_DEBUG_PORT = 2'd0;
	localparam logic [1:0] REG_MIN_LEN    = 2'd1;
	localparam logic [1:0] REG_MAX_LEN    = 2'd2;

	localparam logic [15:0] DEBUG_PORT_RST = 16'd9999;
	localparam logic [10:0] MIN_LEN_RST    = 11'd64;
	localparam logic [10:0] MAX_LEN_RST    = 11'd1518;

	localparam logic [10:0] POS_ETH_HI   = 11'd12;
	localparam logic [10:0] POS_ETH_LO   = 11'd13;
	localparam logic [10:0] POS_PROTO    = 11'd23;
	localparam logic [10:0] POS_PORT_HI  = 11'd36;
	localparam logic [10:0] POS_PORT_LO  = 11'd37;
	localparam logic [10:0] POS_ULEN_HI  = 11'd38;
	localparam logic [10:0] POS_ULEN_LO  = 11'd39;
	localparam logic [10:0] POS_PAYLOAD  = 11'd42;
	localparam logic [10:0] POS_SAT      = 11'd2047;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [7:0]  BREAK_CHAR     = 8'h03;
	localparam int          UDP_HDR_LEN    = 8;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUT,
		OP_GET,
		OP_FLUSH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       brk;
	} beat_t;

endpackage
`default_nettype wire

/* design/udcr_front.sv */
// Front end: accepts input beats, tracks frame position and header fields, classifies beats.
// Depends on udcr_pkg; feeds udcr_queue.
`default_nettype none
module udcr_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [1:0]          mode,
	input  wire  [7:0]          data_byte,
	input  wire                 frame_start,
	input  wire  [10:0]         frame_size,
	input  wire                 in_handler,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [15:0]         cfg_data,
	input  wire                 q_ready,
	output logic                q_push,
	output udcr_pkg::beat_t     q_beat
);
	import udcr_pkg::*;

	logic [15:0]        debug_port_q;
	logic [10:0]        min_len_q;
	logic [10:0]        max_len_q;
	logic [10:0]        pos_q;
	logic [15:0]        eth_q;
	logic [7:0]         proto_q;
	logic [7:0]         port_hi_q;
	logic [7:0]         ulen_hi_q;
	logic signed [16:0] limit_q;
	logic               dbg_q;
	logic               ret_known_q;

	logic [10:0]        idx;
	logic               dbg_cur;
	logic signed [16:0] limit_cur;
	logic               dbg_hit;
	logic signed [16:0] lim_a;
	logic signed [16:0] lim_b;
	logic signed [16:0] lim_min;
	logic signed [16:0] offs;
	logic               in_payload;
	logic               accept;

	assign in_ready  = q_ready;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && q_ready;
	assign q_push    = accept;

	assign idx       = frame_start ? '0 : pos_q;
	assign dbg_cur   = (idx == '0) ? 1'b0 : dbg_q;
	assign limit_cur = (idx == '0) ? 17'sd0 : limit_q;
	assign dbg_hit   = (frame_size >= min_len_q) && (frame_size <= max_len_q) &&
		(eth_q == ETHERTYPE_IPV4) && (proto_q == PROTO_UDP) &&
		({port_hi_q, data_byte} == debug_port_q);
	assign lim_a     = $signed({1'b0, ulen_hi_q, data_byte}) - 17'(UDP_HDR_LEN);
	assign lim_b     = $signed({6'b0, frame_size}) - $signed({6'b0, POS_PAYLOAD});
	assign lim_min   = (lim_a < lim_b) ? lim_a : lim_b;
	assign offs      = $signed({6'b0, idx}) - $signed({6'b0, POS_PAYLOAD});
	assign in_payload = dbg_cur && (idx >= POS_PAYLOAD) && (idx < POS_SAT) &&
		(offs < limit_cur);

	always_comb begin
		q_beat.op   = OP_NONE;
		q_beat.data = data_byte;
		q_beat.brk  = 1'b0;
		unique case (mode)
			MODE_BYTE: begin
				if (idx == POS_PORT_LO && dbg_hit && !ret_known_q) begin
					q_beat.brk = !in_handler;
				end
				if (in_payload) begin
					if (data_byte == BREAK_CHAR && !in_handler) begin
						q_beat.brk = 1'b1;
					end else begin
						q_beat.op = OP_PUT;
					end
				end
			end
			MODE_READ:  q_beat.op = OP_GET;
			MODE_FLUSH: q_beat.op = OP_FLUSH;
			default:    q_beat.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debug_port_q <= DEBUG_PORT_RST;
			min_len_q    <= MIN_LEN_RST;
			max_len_q    <= MAX_LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBUG_PORT: debug_port_q <= cfg_data;
				REG_MIN_LEN:    min_len_q    <= cfg_data[10:0];
				REG_MAX_LEN:    max_len_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			eth_q       <= '0;
			proto_q     <= '0;
			port_hi_q   <= '0;
			ulen_hi_q   <= '0;
			limit_q     <= '0;
			dbg_q       <= 1'b0;
			ret_known_q <= 1'b0;
		end else if (accept && mode == MODE_BYTE) begin
			dbg_q   <= (idx == POS_PORT_LO) ? dbg_hit : dbg_cur;
			limit_q <= (idx == POS_ULEN_LO) ? lim_min : limit_cur;
			unique case (idx)
				POS_ETH_HI:  eth_q[15:8] <= data_byte;
				POS_ETH_LO:  eth_q[7:0]  <= data_byte;
				POS_PROTO:   proto_q     <= data_byte;
				POS_PORT_HI: port_hi_q   <= data_byte;
				POS_PORT_LO: begin
					if (dbg_hit) begin
						ret_known_q <= 1'b1;
					end
				end
				POS_ULEN_HI: ulen_hi_q <= data_byte;
				default: ;
			endcase
			pos_q <= (idx < POS_SAT) ? idx + 11'd1 : POS_SAT;
		end
	end

endmodule
`default_nettype wire

/* design/udcr_queue.sv */
// Short beat queue between the front end and the back end.
// Depends on udcr_pkg for the beat type and depth.
`default_nettype none
module udcr_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  udcr_pkg::beat_t     push_beat,
	output logic                push_ready,
	input  wire                 pop,
	output udcr_pkg::beat_t     pop_beat,
	output logic                pop_valid
);
	import udcr_pkg::*;

	localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QUEUE_DEPTH);

	beat_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QFULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_beat   = ent_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QLAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QLAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/udcr_back.sv */
// Back end: character FIFO with its memory, pointers and full flag, plus the result register.
// Depends on udcr_pkg; drains udcr_queue.
`default_nettype none
module udcr_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	input  udcr_pkg::beat_t     q_beat,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_char,
	output logic                char_valid,
	output logic                break_request,
	output logic                byte_queued
);
	import udcr_pkg::*;

	localparam logic [PTR_W-1:0] PLAST = PTR_W'(FIFO_DEPTH - 1);

	logic [7:0]       mem [FIFO_DEPTH];
	logic [7:0]       rdata_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic             full_q;
	logic             out_valid_q;
	logic             cv_q;
	logic             brk_q;
	logic             qd_q;

	logic             issue;
	logic             empty;
	logic             wr_en;
	logic             rd_en;
	logic [PTR_W-1:0] wp_nxt;
	logic [PTR_W-1:0] rp_nxt;

	assign issue  = q_valid && (!out_valid_q || out_ready);
	assign q_pop  = issue;
	assign empty  = (rp_q == wp_q) && !full_q;
	assign wr_en  = issue && q_beat.op == OP_PUT;
	assign rd_en  = issue && q_beat.op == OP_GET && !empty;
	assign wp_nxt = (wp_q == PLAST) ? '0 : wp_q + 1'b1;
	assign rp_nxt = (rp_q == PLAST) ? '0 : rp_q + 1'b1;

	assign out_valid     = out_valid_q;
	assign out_char      = cv_q ? rdata_q : 8'd0;
	assign char_valid    = cv_q;
	assign break_request = brk_q;
	assign byte_queued   = qd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= q_beat.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (issue) begin
			case (q_beat.op)
				OP_PUT: begin
					wp_q   <= wp_nxt;
					full_q <= (rp_q == wp_nxt);
				end
				OP_GET: begin
					if (!empty) begin
						rp_q   <= rp_nxt;
						full_q <= 1'b0;
					end
				end
				OP_FLUSH: begin
					rp_q   <= wp_q;
					full_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cv_q        <= 1'b0;
			brk_q       <= 1'b0;
			qd_q        <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
			cv_q        <= rd_en;
			brk_q       <= q_beat.brk;
			qd_q        <= wr_en;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* design/udp_debug_char_receiver.sv */
// Top level of the UDP debug character receiver.
// Instantiates udcr_front, udcr_queue and udcr_back; depends on udcr_pkg.
//
// Sustains one beat per cycle on the input while results are taken, with one result beat
// per input beat in order. An accepted beat is written into a two-beat queue, then executed
// against the character FIFO and shown in the result register until it is taken. The rate
// is set by the FIFO memory, which takes one write or one registered read per cycle. The
// character memory needs no clearing pass: only written entries are ever read.
`default_nettype none
module udp_debug_char_receiver (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  mode,
	input  wire  [7:0]  data_byte,
	input  wire         frame_start,
	input  wire  [10:0] frame_size,
	input  wire         in_handler,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_char,
	output logic        char_valid,
	output logic        break_request,
	output logic        byte_queued,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import udcr_pkg::*;

	beat_t f_beat;
	beat_t q_beat;
	logic  f_push;
	logic  q_ready;
	logic  q_valid;
	logic  q_pop;

	udcr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_size  (frame_size),
		.in_handler  (in_handler),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_ready     (q_ready),
		.q_push      (f_push),
		.q_beat      (f_beat)
	);

	udcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_push),
		.push_beat  (f_beat),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_beat   (q_beat),
		.pop_valid  (q_valid)
	);

	udcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_beat        (q_beat),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.char_valid    (char_valid),
		.break_request (break_request),
		.byte_queued   (byte_queued)
	);

	a_no_brk_and_queue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(byte_queued && break_request))
		else $error("break and enqueue on the same beat");

	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && char_valid) |-> (!byte_queued && !break_request))
		else $error("read result carries frame flags");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !char_valid) |-> (out_char == 8'd0))
		else $error("character without a valid read");

	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !q_valid) |=> q_valid)
		else $error("accepted beat missing from queue");

endmodule
`default_nettype wire
